### rtl/core/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

   localparam int unsigned FUNC_W  = 4;
   localparam int unsigned POS_W   = 10;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned COUNT_W = 11;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_BACK  = 4'd0,
      FN_POP_BACK   = 4'd1,
      FN_PUSH_FRONT = 4'd2,
      FN_POP_FRONT  = 4'd3,
      FN_READ       = 4'd4,
      FN_WRITE      = 4'd5,
      FN_CLEAR      = 4'd6,
      FN_FIND       = 4'd7,
      FN_REVERSE    = 4'd8
   } rbd_func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_RANGE     = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } rbd_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD_WAIT,
      ST_FIND,
      ST_REV_A,
      ST_REV_B,
      ST_REV_WA,
      ST_REV_WB,
      ST_DONE
   } rbd_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]   position;
      rbd_func_type       func;
   } rbd_request_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      rbd_status_type     status;
      logic [POS_W-1:0]   found_position;
      logic [VALUE_W-1:0] read_value;
   } rbd_result_type;

endpackage

`default_nettype wire

### rtl/core/rbd_store.sv
`default_nettype none

module rbd_store
   import rbd_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/rbd_ctrl.sv
`default_nettype none

module rbd_ctrl
   import rbd_pkg::*;
#(
   parameter int unsigned CAPACITY      = 1024,
   parameter int unsigned ELEMENT_WIDTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rbd_request_type             req,
   output logic                        res_valid,
   input  logic                        res_ready,
   output rbd_result_type              res,
   output logic                        mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
   output logic [ELEMENT_WIDTH-1:0]    mem_wr_data,
   output logic                        mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
   input  logic [ELEMENT_WIDTH-1:0]    mem_rd_data
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = (CW > POS_W) ? CW : POS_W;

   rbd_state_type state_ff, state_in;

   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   rbd_func_type             func_ff, func_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [ELEMENT_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]            lo_ff, lo_in;
   logic [CW-1:0]            hi_ff, hi_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [CW-1:0]            cmp_idx_ff, cmp_idx_in;
   logic [ELEMENT_WIDTH-1:0] tmp_ff, tmp_in;
   logic [VALUE_W-1:0]       res_value_ff, res_value_in;
   logic [POS_W-1:0]         res_found_ff, res_found_in;
   rbd_status_type           res_status_ff, res_status_in;

   logic is_full;
   logic is_empty;
   logic out_of_range;
   logic find_hit;
   logic rev_more;

   // (head + logical) mod capacity; the sum stays below twice the capacity
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] logical);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(logical);
      if (sum >= (CW+1)'(CAPACITY)) begin
         sum = sum - (CW+1)'(CAPACITY);
      end
      return AW'(sum);
   endfunction

   assign is_full      = (count_ff == CW'(CAPACITY));
   assign is_empty     = (count_ff == '0);
   assign out_of_range = (IW'(pos_ff) >= IW'(count_ff));
   assign find_hit     = cmp_valid_ff && (mem_rd_data == val_ff);
   assign rev_more     = ((lo_ff + CW'(1)) < (hi_ff - CW'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (func_ff)
               FN_POP_BACK, FN_POP_FRONT: state_in = is_empty ? ST_DONE : ST_RD_WAIT;
               FN_READ:    state_in = out_of_range ? ST_DONE : ST_RD_WAIT;
               FN_FIND:    state_in = out_of_range ? ST_DONE : ST_FIND;
               FN_REVERSE: state_in = (count_ff > CW'(1)) ? ST_REV_A : ST_DONE;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_RD_WAIT: state_in = ST_DONE;
         ST_FIND: begin
            if (find_hit || (lo_ff >= count_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_REV_A:  state_in = ST_REV_B;
         ST_REV_B:  state_in = ST_REV_WA;
         ST_REV_WA: state_in = ST_REV_WB;
         ST_REV_WB: state_in = rev_more ? ST_REV_A : ST_DONE;
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = val_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      head_in       = head_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      tmp_in        = tmp_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            func_in       = req.func;
            pos_in        = req.position;
            val_in        = req.item_value[ELEMENT_WIDTH-1:0];
            res_value_in  = '0;
            res_found_in  = '0;
            res_status_in = STAT_OK;
         end
         ST_EXEC: begin
            unique case (func_ff)
               FN_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = slot_of(head_ff, count_ff);
                     count_in    = count_ff + CW'(1);
                  end
               end
               FN_POP_BACK: begin
                  if (is_empty) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = slot_of(head_ff, count_ff - CW'(1));
                     count_in    = count_ff - CW'(1);
                  end
               end
               FN_PUSH_FRONT: begin
                  if (is_full) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     head_in     = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = head_in;
                     count_in    = count_ff + CW'(1);
                  end
               end
               FN_POP_FRONT: begin
                  if (is_empty) begin
                     res_status_in = STAT_EMPTY;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     head_in     = slot_of(head_ff, CW'(1));
                     count_in    = count_ff - CW'(1);
                  end
               end
               FN_READ: begin
                  if (out_of_range) begin
                     res_status_in = STAT_RANGE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = slot_of(head_ff, CW'(pos_ff));
                  end
               end
               FN_WRITE: begin
                  if (out_of_range) begin
                     res_status_in = STAT_RANGE;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = slot_of(head_ff, CW'(pos_ff));
                  end
               end
               FN_CLEAR: begin
                  head_in  = '0;
                  count_in = '0;
               end
               FN_FIND: begin
                  if (out_of_range) begin
                     res_status_in = STAT_NOT_FOUND;
                  end
                  lo_in        = CW'(pos_ff);
                  cmp_valid_in = 1'b0;
               end
               FN_REVERSE: begin
                  lo_in = '0;
                  hi_in = count_ff - CW'(1);
               end
               default: begin
               end
            endcase
         end
         ST_RD_WAIT: begin
            res_value_in = VALUE_W'(mem_rd_data);
         end
         ST_FIND: begin
            // one read issued per cycle, compared as its data returns
            if (find_hit) begin
               res_found_in = POS_W'(cmp_idx_ff);
            end else if (lo_ff < count_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = slot_of(head_ff, lo_ff);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = lo_ff;
               lo_in        = lo_ff + CW'(1);
            end else begin
               res_status_in = STAT_NOT_FOUND;
            end
         end
         ST_REV_A: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = slot_of(head_ff, lo_ff);
         end
         ST_REV_B: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = slot_of(head_ff, hi_ff);
            tmp_in      = mem_rd_data;
         end
         ST_REV_WA: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_of(head_ff, lo_ff);
            mem_wr_data = mem_rd_data;
         end
         ST_REV_WB: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_of(head_ff, hi_ff);
            mem_wr_data = tmp_ff;
            lo_in       = lo_ff + CW'(1);
            hi_in       = hi_ff - CW'(1);
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign res.read_value     = res_value_ff;
   assign res.found_position = res_found_ff;
   assign res.status         = res_status_ff;
   assign res.count          = COUNT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cmp_valid_ff  <= cmp_valid_in;
      cmp_idx_ff    <= cmp_idx_in;
      tmp_ff        <= tmp_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
   end

endmodule

`default_nettype wire

### rtl/core/ring_buffer_deque_unit.sv
`default_nettype none

// Double-ended queue of CAPACITY elements in a circular single-port-read,
// single-port-write memory, addressed by a head pointer and an element count.
// Every request transfer gives exactly one response transfer. One request is
// worked on at a time by a sequencer that drives the memory; the next request
// is taken as soon as the sequencer is back in idle, while the previous
// response may still wait in the output register. Push, write, clear and
// unused codes finish in the execute state; pop and read pass a wait state
// for the memory read; find issues one read per cycle from its start
// position until a match or the last index; reverse does four memory
// accesses per swapped pair on the one read and one write port. There is
// no clearing pass after reset: entries never written are never read as
// elements.
module ring_buffer_deque_unit
   import rbd_pkg::*;
#(
   parameter int unsigned CAPACITY      = 1024,
   parameter int unsigned ELEMENT_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // func[3:0], position[13:4], item_value[77:14], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // read_value, found_position, status, count
);

   localparam int unsigned AW = $clog2(CAPACITY);

   rbd_request_type          req;
   rbd_result_type           res;
   logic                     res_valid;
   logic                     res_ready;
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic [ELEMENT_WIDTH-1:0] mem_wr_data;
   logic                     mem_rd_en;
   logic [AW-1:0]            mem_rd_addr;
   logic [ELEMENT_WIDTH-1:0] mem_rd_data;

   logic           rsp_valid_ff, rsp_valid_in;
   rbd_result_type rsp_data_ff, rsp_data_in;

   assign req.func       = rbd_func_type'(req_tdata[3:0]);
   assign req.position   = req_tdata[13:4];
   assign req.item_value = req_tdata[77:14];

   rbd_ctrl #(
      .CAPACITY      (CAPACITY),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rbd_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEMENT_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: loads when empty or when its transfer completes
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import rbd_pkg::*;

   localparam int DEPTH = 1024;
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd9;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;
   localparam int QUIET_TAIL = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // func, position, item_value, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;        // read_value, found_position, status, count

   ring_buffer_deque_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // deque shadow
   logic [VALUE_W-1:0] deque_cells [DEPTH];
   logic [POS_W-1:0]   head_idx = '0;
   int                 fill_level = 0;

   rbd_request_type pending_ops [$];
   rbd_result_type  expected_rsp [$];
   rbd_request_type cur_req;

   int queued_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int full_refusals = 0;
   int empty_pops = 0;
   int find_misses = 0;
   int peak_level = 0;

   // stimulus shaping
   int                 gen_level = 0;
   logic [VALUE_W-1:0] value_pool [16];

   int gap_left = 0;
   int gap_pct = 0;
   int stall_left = 0;
   int stall_pct = 0;

   function automatic logic [POS_W-1:0] slot(int idx);
      return POS_W'(int'(head_idx) + idx);
   endfunction

   function automatic rbd_result_type deque_step(rbd_request_type rq);
      rbd_result_type     r;
      logic [VALUE_W-1:0] t;
      logic               hit;
      int                 lo;
      int                 hi;
      r = '0;
      r.status = STAT_OK;
      case (rq.func)
         FN_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               r.status = STAT_FULL;
               full_refusals++;
            end else begin
               deque_cells[slot(fill_level)] = rq.item_value;
               fill_level++;
            end
         end
         FN_PUSH_FRONT: begin
            if (fill_level >= DEPTH) begin
               r.status = STAT_FULL;
               full_refusals++;
            end else begin
               head_idx = head_idx - 1'b1;
               deque_cells[head_idx] = rq.item_value;
               fill_level++;
            end
         end
         FN_POP_BACK: begin
            if (fill_level == 0) begin
               r.status = STAT_EMPTY;
               empty_pops++;
            end else begin
               fill_level--;
               r.read_value = deque_cells[slot(fill_level)];
            end
         end
         FN_POP_FRONT: begin
            if (fill_level == 0) begin
               r.status = STAT_EMPTY;
               empty_pops++;
            end else begin
               r.read_value = deque_cells[head_idx];
               head_idx = head_idx + 1'b1;
               fill_level--;
            end
         end
         FN_READ: begin
            if (int'(rq.position) >= fill_level) r.status = STAT_RANGE;
            else r.read_value = deque_cells[slot(rq.position)];
         end
         FN_WRITE: begin
            if (int'(rq.position) >= fill_level) r.status = STAT_RANGE;
            else deque_cells[slot(rq.position)] = rq.item_value;
         end
         FN_CLEAR: begin
            fill_level = 0;
            head_idx = '0;
         end
         FN_FIND: begin
            hit = 1'b0;
            for (int i = int'(rq.position); i < fill_level && !hit; i++) begin
               if (deque_cells[slot(i)] == rq.item_value) begin
                  hit = 1'b1;
                  r.found_position = POS_W'(i);
               end
            end
            if (!hit) begin
               r.status = STAT_NOT_FOUND;
               find_misses++;
            end
         end
         FN_REVERSE: begin
            lo = 0;
            hi = fill_level - 1;
            while (lo < hi) begin
               t = deque_cells[slot(lo)];
               deque_cells[slot(lo)] = deque_cells[slot(hi)];
               deque_cells[slot(hi)] = t;
               lo++;
               hi--;
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(fill_level);
      if (fill_level > peak_level) peak_level = fill_level;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= 60)
         $display("mismatch in %s at response %0d: got %0h, expected %0h",
                  what, checked_count, got, want);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(deque_step(cur_req));
            sent_count++;
            if (sent_count % 40 == 0) begin
               case ($urandom_range(3))
                  0: gap_pct = 0;
                  1: gap_pct = 8;
                  2: gap_pct = 25;
                  default: gap_pct = 60;
               endcase
            end
         end
         if (req_tvalid && !req_tready) begin
            // hold the item until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            cur_req = pending_ops.pop_front();
            req_tdata <= {2'b00, cur_req};
            req_tvalid <= 1'b1;
            if (pending_ops.size() >= QUIET_TAIL && $urandom_range(99) < gap_pct)
               gap_left = $urandom_range(1, 13);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   rbd_result_type got_rsp;
   rbd_result_type want_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata[63:0], '0);
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (got_rsp.read_value !== want_rsp.read_value)
                  report_mismatch("read_value", got_rsp.read_value, want_rsp.read_value);
               if (got_rsp.found_position !== want_rsp.found_position)
                  report_mismatch("found_position", got_rsp.found_position,
                                  want_rsp.found_position);
               if (got_rsp.status !== want_rsp.status)
                  report_mismatch("status", got_rsp.status, want_rsp.status);
               if (got_rsp.count !== want_rsp.count)
                  report_mismatch("count", got_rsp.count, want_rsp.count);
            end
            checked_count++;
            if (checked_count % 50 == 0) stall_pct = 20 * $urandom_range(3);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (pending_ops.size() >= QUIET_TAIL && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus
   task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
      rbd_request_type rq;
      rq.func = rbd_func_type'(fn);
      rq.position = pos;
      rq.item_value = val;
      pending_ops.push_back(rq);
      queued_count++;
      case (fn)
         FN_PUSH_BACK, FN_PUSH_FRONT: begin
            if (gen_level < DEPTH) gen_level++;
            value_pool[$urandom_range(15)] = val;
         end
         FN_POP_BACK, FN_POP_FRONT: if (gen_level > 0) gen_level--;
         FN_WRITE: value_pool[$urandom_range(15)] = val;
         FN_CLEAR: gen_level = 0;
         default: ;
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 35) return value_pool[$urandom_range(15)];
      if (sel < 47) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return {1'b1, 63'd0};
            default: return 64'd1;
         endcase
      end
      return {$urandom, $urandom};
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70 && gen_level > 0) return POS_W'($urandom_range(gen_level - 1));
      if (sel < 80) return POS_W'(gen_level);
      return POS_W'($urandom);
   endfunction

   task automatic random_op(input int ceiling);
      int unsigned        sel;
      logic [FUNC_W-1:0]  fn;
      logic [VALUE_W-1:0] val;
      logic [POS_W-1:0]   pos;
      sel = $urandom_range(99);
      if (sel < 18) fn = FN_PUSH_BACK;
      else if (sel < 34) fn = FN_PUSH_FRONT;
      else if (sel < 45) fn = FN_POP_BACK;
      else if (sel < 56) fn = FN_POP_FRONT;
      else if (sel < 67) fn = FN_READ;
      else if (sel < 77) fn = FN_WRITE;
      else if (sel < 87) fn = FN_FIND;
      else if (sel < 91) fn = FN_REVERSE;
      else if (sel < 94) fn = FN_CLEAR;
      else fn = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      if (gen_level >= ceiling && (fn == FN_PUSH_BACK || fn == FN_PUSH_FRONT))
         fn = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
      val = pick_value();
      pos = pick_pos();
      if (fn == FN_FIND) begin
         if ($urandom_range(99) < 60) val = value_pool[$urandom_range(15)];
         if ($urandom_range(99) < 50) pos = '0;
      end
      queue_op(fn, pos, val);
   endtask

   initial begin
      for (int i = 0; i < 16; i++) value_pool[i] = {$urandom, $urandom};

      // empty deque corner cases
      queue_op(FN_POP_BACK, '0, '0);
      queue_op(FN_POP_FRONT, '1, '1);
      queue_op(FN_READ, '0, '0);
      queue_op(FN_WRITE, '0, '1);
      queue_op(FN_FIND, '0, '0);
      queue_op(FN_REVERSE, '0, '0);
      queue_op(FN_CLEAR, '0, '0);
      // small contents, index bounds and wrap of the head below zero
      queue_op(FN_PUSH_BACK, '0, '1);
      queue_op(FN_PUSH_FRONT, '1, '0);
      queue_op(FN_REVERSE, '0, '0);
      queue_op(FN_READ, 10'd0, '0);
      queue_op(FN_READ, 10'd1, '0);
      queue_op(FN_READ, '1, '0);
      queue_op(FN_WRITE, 10'd1, 64'haaaa_aaaa_aaaa_aaaa);
      queue_op(FN_FIND, 10'd0, '0);
      queue_op(FN_FIND, 10'd2, '1);
      queue_op(FN_POP_FRONT, '0, '0);
      queue_op(FN_REVERSE, '0, '0);
      queue_op(FN_SPARE_LO, '1, '1);
      queue_op(FN_SPARE_HI, '0, '0);
      queue_op(FN_PUSH_BACK, '0, 64'h5555_5555_5555_5555);
      queue_op(FN_FIND, 10'd0, 64'h5555_5555_5555_5555);
      queue_op(FN_POP_BACK, '0, '0);
      queue_op(FN_POP_FRONT, '0, '0);
      queue_op(FN_CLEAR, '0, '0);

      // fill to capacity with traffic mixed in
      while (gen_level < DEPTH) begin
         if ($urandom_range(999) < 8) queue_op(FN_REVERSE, '0, '0);
         else if ($urandom_range(99) < 8) begin
            case ($urandom_range(2))
               0: queue_op(FN_READ, pick_pos(), '0);
               1: queue_op(FN_WRITE, pick_pos(), pick_value());
               default: queue_op(FN_FIND, pick_pos(), value_pool[$urandom_range(15)]);
            endcase
         end else begin
            queue_op($urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_pos(),
                     pick_value());
         end
      end
      queue_op(FN_PUSH_BACK, '0, '1);
      queue_op(FN_PUSH_FRONT, '1, '0);
      queue_op(FN_READ, '1, '0);
      queue_op(FN_WRITE, '1, 64'hfeed_0000_0000_beef);
      queue_op(FN_FIND, 10'd600, 64'hfeed_0000_0000_beef);
      queue_op(FN_REVERSE, '0, '0);
      queue_op(FN_READ, '0, '0);
      queue_op(FN_FIND, '0, {$urandom, $urandom});
      queue_op(FN_POP_BACK, '0, '0);
      queue_op(FN_POP_FRONT, '0, '0);
      queue_op(FN_PUSH_FRONT, '0, pick_value());
      queue_op(FN_CLEAR, '0, '0);

      for (int n = 0; n < 100; n++) random_op(48);

      while (sent_count < queued_count || expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("ran %0d operations, checked %0d responses, peak depth %0d",
               sent_count, checked_count, peak_level);
      $display("full refusals %0d, empty pops %0d, unmatched finds %0d",
               full_refusals, empty_pops, find_misses);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### ring_buffer_deque_unit.f
rtl/core/rbd_pkg.sv
rtl/core/rbd_store.sv
rtl/core/rbd_ctrl.sv
rtl/core/ring_buffer_deque_unit.sv
tb/sv/tb.sv
